@@ src/sdpg_pkg.sv @@
// Shared constants for the stereo distance pan gain block.
`timescale 1ns / 1ps
package sdpg_pkg;

  // Register indexes on the configuration port.
  typedef enum logic {
    REG_NEAR = 1'b0,
    REG_FAR  = 1'b1
  } reg_idx_e;

  // Distances in Q16.16 metres.
  localparam logic [30:0] NEAR_DEFAULT = 31'd6554;
  localparam logic [30:0] FAR_DEFAULT  = 31'd655360;
  localparam logic [31:0] ONE_METRE    = 32'd65536;

  // Unity gain in Q1.15.
  localparam logic [15:0] UNITY = 16'd32768;

  // Quarter-sine Taylor coefficients in Q2.30, highest order first.
  localparam logic [31:0] SIN_COEF [0:4] = '{
    32'd172272, 32'd5026995, 32'd85569306, 32'd693598668, 32'd1686629713
  };

endpackage

@@ src/stereo_distance_pan_gains_top.sv @@
// Top level: pipelined distance attenuation and constant-power pan gains.
//
//  Channel   | Direction | Contents
//  ----------+-----------+------------------------------------------------
//  s_axis    | in        | listener_x, listener_y, source_x, source_y
//  m_axis    | out       | left_gain, right_gain
//  APB       | in/out    | near_distance (0x0), far_distance (0x4)
//
// One transaction is taken per cycle while the pipeline is not held. The
// 32 square root stages and the 16 stages of each divider set the depth.
// Reset clears all valid bits and loads the register defaults. A stalled
// output fills a one-entry skid register, after which the whole pipeline
// holds until the result is taken.
`timescale 1ns / 1ps
module stereo_distance_pan_gains_top
  import sdpg_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // listener_x[31:0], listener_y[63:32], source_x[95:64], source_y[127:96]
  input  logic [127:0] s_axis_tdata_i,
  // Output stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // left_gain[15:0], right_gain[31:16]
  output logic [31:0]  m_axis_tdata_o,
  // Configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int SqSteps  = 32;
  localparam int DivSteps = 16;
  localparam int SinSteps = 4;

  // Configuration registers.
  logic [30:0] near_q, far_q;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q <= NEAR_DEFAULT;
      far_q  <= FAR_DEFAULT;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_NEAR: near_q <= pwdata[30:0];
        REG_FAR:  far_q  <= pwdata[30:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_NEAR: prdata = {1'b0, near_q};
      REG_FAR:  prdata = {1'b0, far_q};
      default:  prdata = '0;
    endcase
  end

  // Effective near and far distances; the user keeps them stable while items are in flight (not enforced here).
  logic [30:0] nd;
  logic [31:0] fd;
  always_comb begin
    nd = (near_q != '0) ? near_q : NEAR_DEFAULT;
    fd = (far_q > nd) ? {1'b0, far_q} : ({1'b0, nd} + ONE_METRE);
  end

  // Global advance: the pipeline holds only while the skid register is full.
  logic en;
  logic skid_v_q;
  assign en              = !skid_v_q;
  assign s_axis_tready_o = en;

  // Stage f0: coordinate differences.
  logic               f0_v_q;
  logic signed [32:0] f0_dx_q, f0_dy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f0_v_q <= 1'b0;
    else if (en) f0_v_q <= s_axis_tvalid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      f0_dx_q <= $signed({s_axis_tdata_i[95], s_axis_tdata_i[95:64]})
               - $signed({s_axis_tdata_i[31], s_axis_tdata_i[31:0]});
      f0_dy_q <= $signed({s_axis_tdata_i[127], s_axis_tdata_i[127:96]})
               - $signed({s_axis_tdata_i[63], s_axis_tdata_i[63:32]});
    end
  end

  // Stage f1: magnitudes and the sign of dx.
  logic        f1_v_q, f1_neg_q;
  logic [31:0] f1_adx_q, f1_ady_q;
  logic [32:0] abs_dx, abs_dy;
  assign abs_dx = f0_dx_q[32] ? 33'(-f0_dx_q) : 33'(f0_dx_q);
  assign abs_dy = f0_dy_q[32] ? 33'(-f0_dy_q) : 33'(f0_dy_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f1_v_q <= 1'b0;
    else if (en) f1_v_q <= f0_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_adx_q <= abs_dx[31:0];
      f1_ady_q <= abs_dy[31:0];
      f1_neg_q <= f0_dx_q[32];
    end
  end

  // Stage f2: squares.
  logic        f2_v_q, f2_neg_q;
  logic [31:0] f2_adx_q;
  logic [63:0] f2_sx_q, f2_sy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f2_v_q <= 1'b0;
    else if (en) f2_v_q <= f1_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      f2_sx_q  <= 64'(f1_adx_q) * 64'(f1_adx_q);
      f2_sy_q  <= 64'(f1_ady_q) * 64'(f1_ady_q);
      f2_adx_q <= f1_adx_q;
      f2_neg_q <= f1_neg_q;
    end
  end

  // Square root pipeline: entry 0 holds the sum, each stage settles one root bit.
  logic        sq_v_q   [0:SqSteps];
  logic        sq_neg_q [0:SqSteps];
  logic        sq_ovf_q [0:SqSteps];
  logic [31:0] sq_adx_q [0:SqSteps];
  logic [63:0] sq_rad_q [0:SqSteps];
  logic [33:0] sq_rem_q [0:SqSteps];
  logic [31:0] sq_root_q[0:SqSteps];
  logic [64:0] sum;
  logic [33:0] sq_rem_d [0:SqSteps-1];
  logic [31:0] sq_root_d[0:SqSteps-1];

  assign sum = {1'b0, f2_sx_q} + {1'b0, f2_sy_q};

  always_comb begin
    logic [35:0] trial, subv;
    for (int k = 0; k < SqSteps; k++) begin
      trial = {sq_rem_q[k], sq_rad_q[k][63:62]};
      subv  = {2'b00, sq_root_q[k], 2'b01};
      if (trial >= subv) begin
        sq_rem_d[k]  = 34'(trial - subv);
        sq_root_d[k] = {sq_root_q[k][30:0], 1'b1};
      end else begin
        sq_rem_d[k]  = trial[33:0];
        sq_root_d[k] = {sq_root_q[k][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= SqSteps; k++) sq_v_q[k] <= 1'b0;
    end else if (en) begin
      sq_v_q[0] <= f2_v_q;
      for (int k = 0; k < SqSteps; k++) sq_v_q[k+1] <= sq_v_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
      sq_rad_q[0]  <= sum[63:0];
      sq_ovf_q[0]  <= sum[64];
      sq_adx_q[0]  <= f2_adx_q;
      sq_neg_q[0]  <= f2_neg_q;
      for (int k = 0; k < SqSteps; k++) begin
        sq_rem_q[k+1]  <= sq_rem_d[k];
        sq_root_q[k+1] <= sq_root_d[k];
        sq_rad_q[k+1]  <= {sq_rad_q[k][61:0], 2'b00};
        sq_ovf_q[k+1]  <= sq_ovf_q[k];
        sq_adx_q[k+1]  <= sq_adx_q[k];
        sq_neg_q[k+1]  <= sq_neg_q[k];
      end
    end
  end

  // Divider setup from the distance: attenuation and pan numerators.
  logic [31:0] distance, att_den, far_gap;
  logic [47:0] att_num, pan_num;
  assign distance = sq_root_q[SqSteps];
  assign att_den  = fd - {1'b0, nd};
  assign far_gap  = fd - distance;
  assign att_num  = {1'b0, far_gap, 15'd0} + {17'd0, att_den[31:1]};
  assign pan_num  = {1'b0, sq_adx_q[SqSteps], 15'd0} + {17'd0, distance[31:1]};

  // Two restoring dividers side by side, one quotient bit per stage.
  logic        dv_v_q    [0:DivSteps];
  logic        dv_full_q [0:DivSteps];
  logic        dv_mute_q [0:DivSteps];
  logic        dv_zero_q [0:DivSteps];
  logic        dv_neg_q  [0:DivSteps];
  logic [31:0] dv_arem_q [0:DivSteps];
  logic [15:0] dv_alow_q [0:DivSteps];
  logic [31:0] dv_aden_q [0:DivSteps];
  logic [15:0] dv_aquo_q [0:DivSteps];
  logic [31:0] dv_prem_q [0:DivSteps];
  logic [15:0] dv_plow_q [0:DivSteps];
  logic [31:0] dv_pden_q [0:DivSteps];
  logic [15:0] dv_pquo_q [0:DivSteps];
  logic [31:0] dv_arem_d [0:DivSteps-1];
  logic [15:0] dv_aquo_d [0:DivSteps-1];
  logic [31:0] dv_prem_d [0:DivSteps-1];
  logic [15:0] dv_pquo_d [0:DivSteps-1];

  always_comb begin
    logic [32:0] ta, tp;
    for (int k = 0; k < DivSteps; k++) begin
      ta = {dv_arem_q[k], dv_alow_q[k][15]};
      tp = {dv_prem_q[k], dv_plow_q[k][15]};
      if (ta >= {1'b0, dv_aden_q[k]}) begin
        dv_arem_d[k] = 32'(ta - {1'b0, dv_aden_q[k]});
        dv_aquo_d[k] = {dv_aquo_q[k][14:0], 1'b1};
      end else begin
        dv_arem_d[k] = ta[31:0];
        dv_aquo_d[k] = {dv_aquo_q[k][14:0], 1'b0};
      end
      if (tp >= {1'b0, dv_pden_q[k]}) begin
        dv_prem_d[k] = 32'(tp - {1'b0, dv_pden_q[k]});
        dv_pquo_d[k] = {dv_pquo_q[k][14:0], 1'b1};
      end else begin
        dv_prem_d[k] = tp[31:0];
        dv_pquo_d[k] = {dv_pquo_q[k][14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DivSteps; k++) dv_v_q[k] <= 1'b0;
    end else if (en) begin
      dv_v_q[0] <= sq_v_q[SqSteps];
      for (int k = 0; k < DivSteps; k++) dv_v_q[k+1] <= dv_v_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_full_q[0] <= (distance <= {1'b0, nd});
      dv_mute_q[0] <= sq_ovf_q[SqSteps] || (distance >= fd);
      dv_zero_q[0] <= (distance == '0);
      dv_neg_q[0]  <= sq_neg_q[SqSteps];
      dv_arem_q[0] <= att_num[47:16];
      dv_alow_q[0] <= att_num[15:0];
      dv_aden_q[0] <= att_den;
      dv_aquo_q[0] <= '0;
      dv_prem_q[0] <= pan_num[47:16];
      dv_plow_q[0] <= pan_num[15:0];
      dv_pden_q[0] <= distance;
      dv_pquo_q[0] <= '0;
      for (int k = 0; k < DivSteps; k++) begin
        dv_full_q[k+1] <= dv_full_q[k];
        dv_mute_q[k+1] <= dv_mute_q[k];
        dv_zero_q[k+1] <= dv_zero_q[k];
        dv_neg_q[k+1]  <= dv_neg_q[k];
        dv_arem_q[k+1] <= dv_arem_d[k];
        dv_alow_q[k+1] <= {dv_alow_q[k][14:0], 1'b0};
        dv_aden_q[k+1] <= dv_aden_q[k];
        dv_aquo_q[k+1] <= dv_aquo_d[k];
        dv_prem_q[k+1] <= dv_prem_d[k];
        dv_plow_q[k+1] <= {dv_plow_q[k][14:0], 1'b0};
        dv_pden_q[k+1] <= dv_pden_q[k];
        dv_pquo_q[k+1] <= dv_pquo_d[k];
      end
    end
  end

  // Attenuation and pan position; lane 0 is left, lane 1 is right.
  logic [15:0] att, mag;
  logic [16:0] pos;
  always_comb begin
    if (dv_mute_q[DivSteps]) begin
      att = '0;
    end else if (dv_full_q[DivSteps]) begin
      att = UNITY;
    end else begin
      att = dv_aquo_q[DivSteps];
    end
    mag = (dv_pquo_q[DivSteps] > UNITY) ? UNITY : dv_pquo_q[DivSteps];
    if (dv_zero_q[DivSteps]) begin
      pos = {1'b0, UNITY};
    end else if (dv_neg_q[DivSteps]) begin
      pos = {1'b0, UNITY} - {1'b0, mag};
    end else begin
      pos = {1'b0, UNITY} + {1'b0, mag};
    end
  end

  logic        pn_v_q;
  logic [15:0] pn_att_q;
  logic [16:0] pn_z_q [0:1];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pn_v_q <= 1'b0;
    else if (en) pn_v_q <= dv_v_q[DivSteps];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      pn_att_q  <= att;
      pn_z_q[0] <= 17'h10000 - pos;
      pn_z_q[1] <= pos;
    end
  end

  // Quarter-sine Horner chain, one coefficient per stage.
  logic        sn_v_q   [0:SinSteps];
  logic [15:0] sn_att_q [0:SinSteps];
  logic [16:0] sn_z_q   [0:SinSteps][0:1];
  logic [16:0] sn_z2_q  [0:SinSteps][0:1];
  logic [31:0] sn_h_q   [0:SinSteps][0:1];
  logic [33:0] z_sq     [0:1];
  logic [48:0] h_prod   [0:SinSteps-1][0:1];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      z_sq[l] = 34'(pn_z_q[l]) * 34'(pn_z_q[l]);
      for (int s = 0; s < SinSteps; s++) begin
        h_prod[s][l] = 49'(sn_h_q[s][l]) * 49'(sn_z2_q[s][l]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= SinSteps; s++) sn_v_q[s] <= 1'b0;
    end else if (en) begin
      sn_v_q[0] <= pn_v_q;
      for (int s = 0; s < SinSteps; s++) sn_v_q[s+1] <= sn_v_q[s];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sn_att_q[0] <= pn_att_q;
      for (int l = 0; l < 2; l++) begin
        sn_z_q[0][l]  <= pn_z_q[l];
        sn_z2_q[0][l] <= z_sq[l][32:16];
        sn_h_q[0][l]  <= SIN_COEF[0];
      end
      for (int s = 0; s < SinSteps; s++) begin
        sn_att_q[s+1] <= sn_att_q[s];
        for (int l = 0; l < 2; l++) begin
          sn_z_q[s+1][l]  <= sn_z_q[s][l];
          sn_z2_q[s+1][l] <= sn_z2_q[s][l];
          sn_h_q[s+1][l]  <= SIN_COEF[s+1] - h_prod[s][l][47:16];
        end
      end
    end
  end

  // Final sine product, then rounding to Q1.15 with a clamp at unity.
  logic        y_v_q, g_v_q;
  logic [15:0] y_att_q, g_att_q;
  logic [31:0] y_q [0:1];
  logic [15:0] g_q [0:1];
  logic [48:0] y_prod [0:1];
  logic [16:0] g_rnd  [0:1];
  logic [31:0] out_prod [0:1];
  logic [15:0] gain   [0:1];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      y_prod[l]   = 49'(sn_h_q[SinSteps][l]) * 49'(sn_z_q[SinSteps][l]);
      g_rnd[l]    = 17'((33'(y_q[l]) + 33'd16384) >> 15);
      out_prod[l] = (32'(g_q[l]) * 32'(g_att_q)) + 32'd16384;
      gain[l]     = out_prod[l][30:15];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_v_q <= 1'b0;
      g_v_q <= 1'b0;
    end else if (en) begin
      y_v_q <= sn_v_q[SinSteps];
      g_v_q <= y_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      y_att_q <= sn_att_q[SinSteps];
      g_att_q <= y_att_q;
      for (int l = 0; l < 2; l++) begin
        y_q[l] <= y_prod[l][47:16];
        g_q[l] <= (g_rnd[l] > {1'b0, UNITY}) ? UNITY : g_rnd[l][15:0];
      end
    end
  end

  // Output register with a one-entry skid register behind it.
  logic        out_v_q;
  logic [31:0] out_q, skid_q;
  logic        take, arrive;
  assign take   = !out_v_q || m_axis_tready_i;
  assign arrive = en && g_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (take) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= arrive;
      end
    end else if (arrive) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= skid_v_q ? skid_q : {gain[1], gain[0]};
    end else if (arrive) begin
      skid_q <= {gain[1], gain[0]};
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q;

endmodule

@@ src/sdpg_checker.sv @@
// Port-level checker for the stereo distance pan gain block, with its bind.
`timescale 1ns / 1ps
module sdpg_checker
  import sdpg_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [31:0]  m_axis_tdata_o,
  input logic         psel,
  input logic         penable,
  input logic         pwrite,
  input logic [2:0]   paddr,
  input logic [31:0]  pwdata,
  input logic [31:0]  prdata
);

  // A stalled result transaction holds its data.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output transaction changed while stalled");

  // Gains never exceed unity.
  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[15:0] <= UNITY) && (m_axis_tdata_o[31:16] <= UNITY))
    else $error("gain above unity");

  // The input side only backs off while a result waits at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled without a pending result");

  // A register reads back what was just written to it, masked to 31 bits.
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite) ##1 (paddr[2] == $past(paddr[2]))
      |-> prdata == {1'b0, $past(pwdata[30:0])})
    else $error("register read-back mismatch");

endmodule

bind stereo_distance_pan_gains_top sdpg_checker u_sdpg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .paddr           (paddr),
  .pwdata          (pwdata),
  .prdata          (prdata)
);
